/* rtl/deadline_job_sequencer_macros.svh */
// Assertion macros used by the checker file of the job sequencer.
`ifndef DEADLINE_JOB_SEQUENCER_MACROS_SVH
`define DEADLINE_JOB_SEQUENCER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DJS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DJS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/djs_pkg.sv */
// Types, widths and constants shared by the job sequencer modules.
package djs_pkg;

  localparam int unsigned PROFIT_W   = 16;
  localparam int unsigned DL_W       = 6;
  localparam int unsigned VALUE_W    = 21;
  localparam int unsigned TOTAL_W    = 22;
  localparam int unsigned DEF_MAX_TASKS  = 32;
  localparam int unsigned DEF_SLOT_COUNT = 32;
  localparam int unsigned MID_DEPTH  = 4;
  localparam int unsigned OUT_DEPTH  = 2;

  // Task record handed from the front end to the scheduler.
  typedef struct packed {
    logic [PROFIT_W-1:0] profit;
    logic [DL_W-1:0]     deadline;
    logic                last;
    logic                store_en;
  } djs_task_t;

  // One result record as it leaves the block.
  typedef struct packed {
    logic               is_total;
    logic [VALUE_W-1:0] value;
    logic [DL_W-1:0]    slot;
    logic               last;
  } djs_result_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_PICK,
    ST_SLOT,
    ST_EMIT,
    ST_TOTAL
  } djs_state_e;

endpackage

/* rtl/deadline_job_sequencer.sv */
// Greedy job sequencer with deadlines: tasks in, scheduled tasks and a total out.
//
// Input side is a queue: a task transfers when push is high and full is low.
// Tasks load at one per cycle, while no run is busy, into a task store of
// MAX_TASKS entries; extra tasks beyond that are dropped. The task with
// last_task_i set starts a run. During a run, each of the n held tasks costs
// one selection scan (a registered read of the task store and a compare per
// entry), a pick of the winner, and a slot search that walks down from the
// deadline before the record is handed on.
// Up to four further tasks are buffered while a run is busy; full then rises.
// Result side is a queue: the oldest result shows while empty is low and
// transfers when pop is high. One record per scheduled task comes out in
// scheduling order, then a total record with last_result_o set.
// If the receiver stalls, the scheduler waits on a full result queue.
// Reset empties both queues, forgets any partial set and returns to loading.
module deadline_job_sequencer
  import djs_pkg::*;
#(
  parameter int unsigned MAX_TASKS  = DEF_MAX_TASKS,
  parameter int unsigned SLOT_COUNT = DEF_SLOT_COUNT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [PROFIT_W-1:0] task_profit_i,
  input  logic [DL_W-1:0]     task_deadline_i,
  input  logic                last_task_i,
  output logic                empty,
  input  logic                pop,
  output logic                is_total_o,
  output logic [VALUE_W-1:0]  result_value_o,
  output logic [DL_W-1:0]     slot_taken_o,
  output logic                last_result_o
);

  localparam int unsigned TASK_W = $bits(djs_task_t);
  localparam int unsigned RES_W  = $bits(djs_result_t);

  logic             mid_push, mid_full, mid_pop, mid_empty;
  djs_task_t        front_task, mid_task;
  logic [TASK_W-1:0] mid_raw;
  logic             out_push, out_full;
  djs_result_t      back_res, out_res;
  logic [RES_W-1:0] out_raw;

  djs_front #(
    .MAX_TASKS  (MAX_TASKS),
    .SLOT_COUNT (SLOT_COUNT)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .task_profit_i   (task_profit_i),
    .task_deadline_i (task_deadline_i),
    .last_task_i     (last_task_i),
    .full_o          (full),
    .mid_push_o      (mid_push),
    .mid_data_o      (front_task),
    .mid_full_i      (mid_full)
  );

  djs_fifo #(
    .WIDTH (TASK_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (front_task),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_raw),
    .empty_o (mid_empty)
  );

  assign mid_task = djs_task_t'(mid_raw);

  djs_back #(
    .MAX_TASKS  (MAX_TASKS),
    .SLOT_COUNT (SLOT_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_data_i  (mid_task),
    .mid_empty_i (mid_empty),
    .mid_pop_o   (mid_pop),
    .out_push_o  (out_push),
    .out_data_o  (back_res),
    .out_full_i  (out_full)
  );

  djs_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (back_res),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_raw),
    .empty_o (empty)
  );

  assign out_res        = djs_result_t'(out_raw);
  assign is_total_o     = out_res.is_total;
  assign result_value_o = out_res.value;
  assign slot_taken_o   = out_res.slot;
  assign last_result_o  = out_res.last;

endmodule

/* rtl/djs_fifo.sv */
// Small register-based first-in first-out queue.
module djs_fifo
  import djs_pkg::*;
#(
  parameter int unsigned WIDTH = $bits(djs_task_t),
  parameter int unsigned DEPTH = MID_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNTW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = store_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNTW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wptr_q] <= data_i;
    end
  end

endmodule

/* rtl/djs_front.sv */
// Front end: accepts tasks, clamps deadlines and drops tasks beyond the store size.
module djs_front
  import djs_pkg::*;
#(
  parameter int unsigned MAX_TASKS  = DEF_MAX_TASKS,
  parameter int unsigned SLOT_COUNT = DEF_SLOT_COUNT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [PROFIT_W-1:0] task_profit_i,
  input  logic [DL_W-1:0]     task_deadline_i,
  input  logic                last_task_i,
  output logic                full_o,
  output logic                mid_push_o,
  output djs_task_t           mid_data_o,
  input  logic                mid_full_i
);

  localparam int unsigned CW = $clog2(MAX_TASKS + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic          accept;
  logic          store_en;

  assign full_o   = mid_full_i;
  assign accept   = push_i && !mid_full_i;
  assign store_en = (cnt_q < CW'(MAX_TASKS));

  // A task that finds the store full is dropped unless it closes the set.
  assign mid_push_o = accept && (store_en || last_task_i);

  always_comb begin
    mid_data_o.profit   = task_profit_i;
    mid_data_o.deadline = (task_deadline_i > DL_W'(SLOT_COUNT)) ? DL_W'(SLOT_COUNT)
                                                               : task_deadline_i;
    mid_data_o.last     = last_task_i;
    mid_data_o.store_en = store_en;
  end

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      if (last_task_i) begin
        cnt_d = '0;
      end else if (store_en) begin
        cnt_d = cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

/* rtl/djs_back.sv */
// Back end: stores the set, picks tasks by profit and assigns slots.
module djs_back
  import djs_pkg::*;
#(
  parameter int unsigned MAX_TASKS  = DEF_MAX_TASKS,
  parameter int unsigned SLOT_COUNT = DEF_SLOT_COUNT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  djs_task_t   mid_data_i,
  input  logic        mid_empty_i,
  output logic        mid_pop_o,
  output logic        out_push_o,
  output djs_result_t out_data_o,
  input  logic        out_full_i
);

  localparam int unsigned IW   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CW   = $clog2(MAX_TASKS + 1);
  localparam int unsigned SW   = $clog2(SLOT_COUNT + 1);
  localparam int unsigned SIW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned MW   = PROFIT_W + DL_W;

  djs_state_e state_q, state_d;

  logic [MW-1:0]         mem [MAX_TASKS];
  logic [MW-1:0]         rd_q;
  logic                  mem_we;
  logic [MW-1:0]         mem_wd;

  logic [CW-1:0]         wcnt_q, wcnt_d;
  logic [CW-1:0]         n_q, n_d;
  logic [CW-1:0]         k_q, k_d;
  logic [IW-1:0]         i_q, i_d;
  logic [MAX_TASKS-1:0]  visited_q, visited_d;
  logic                  found_q, found_d;
  logic [IW-1:0]         best_idx_q, best_idx_d;
  logic [PROFIT_W-1:0]   best_prof_q, best_prof_d;
  logic [DL_W-1:0]       best_dl_q, best_dl_d;
  logic [SLOT_COUNT-1:0] busy_q, busy_d;
  logic [SW-1:0]         s_q, s_d;
  logic [TOTAL_W-1:0]    total_q, total_d;

  logic [PROFIT_W-1:0]   rd_prof;
  logic [DL_W-1:0]       rd_dl;
  logic [SW-1:0]         slot_m1;
  logic                  take;
  logic                  scan_done;
  logic                  run_done;
  logic                  slot_free;
  logic [CW-1:0]         n_load;

  assign rd_prof   = rd_q[MW-1:DL_W];
  assign rd_dl     = rd_q[DL_W-1:0];
  assign slot_m1   = s_q - SW'(1);
  assign slot_free = !busy_q[slot_m1[SIW-1:0]];
  // Strict compare keeps the earliest loaded task among equal profits.
  assign take      = !visited_q[i_q] && (!found_q || (rd_prof > best_prof_q));
  assign scan_done = (CW'(i_q) + CW'(1) == n_q);
  assign run_done  = (k_q + CW'(1) == n_q);
  assign n_load    = wcnt_q + CW'(mid_data_i.store_en);
  assign mem_we    = (state_q == ST_LOAD) && !mid_empty_i && mid_data_i.store_en;
  assign mem_wd    = {mid_data_i.profit, mid_data_i.deadline};

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (!mid_empty_i && mid_data_i.last) begin
          state_d = (n_load == '0) ? ST_TOTAL : ST_SCAN_RD;
        end
      end
      ST_SCAN_RD:  state_d = ST_SCAN_CMP;
      ST_SCAN_CMP: state_d = scan_done ? ST_PICK : ST_SCAN_RD;
      ST_PICK:     state_d = found_q ? ST_SLOT : ST_TOTAL;
      ST_SLOT: begin
        if (s_q == '0) begin
          state_d = run_done ? ST_TOTAL : ST_SCAN_RD;
        end else if (slot_free) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_full_i) begin
          state_d = run_done ? ST_TOTAL : ST_SCAN_RD;
        end
      end
      ST_TOTAL: begin
        if (!out_full_i) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    mid_pop_o   = 1'b0;
    out_push_o  = 1'b0;
    out_data_o  = '0;
    wcnt_d      = wcnt_q;
    n_d         = n_q;
    k_d         = k_q;
    i_d         = i_q;
    visited_d   = visited_q;
    found_d     = found_q;
    best_idx_d  = best_idx_q;
    best_prof_d = best_prof_q;
    best_dl_d   = best_dl_q;
    busy_d      = busy_q;
    s_d         = s_q;
    total_d     = total_q;
    case (state_q)
      ST_LOAD: begin
        mid_pop_o = !mid_empty_i;
        if (!mid_empty_i) begin
          wcnt_d = n_load;
          if (mid_data_i.last) begin
            n_d       = n_load;
            wcnt_d    = '0;
            k_d       = '0;
            i_d       = '0;
            found_d   = 1'b0;
            visited_d = '0;
            busy_d    = '0;
            total_d   = '0;
          end
        end
      end
      ST_SCAN_CMP: begin
        if (take) begin
          found_d     = 1'b1;
          best_idx_d  = i_q;
          best_prof_d = rd_prof;
          best_dl_d   = rd_dl;
        end
        if (!scan_done) begin
          i_d = i_q + IW'(1);
        end
      end
      ST_PICK: begin
        if (found_q) begin
          visited_d[best_idx_q] = 1'b1;
          s_d = best_dl_q[SW-1:0];
        end
      end
      ST_SLOT: begin
        if (s_q == '0) begin
          k_d     = k_q + CW'(1);
          i_d     = '0;
          found_d = 1'b0;
        end else if (slot_free) begin
          busy_d[slot_m1[SIW-1:0]] = 1'b1;
          total_d = total_q + TOTAL_W'(best_prof_q);
        end else begin
          s_d = slot_m1;
        end
      end
      ST_EMIT: begin
        out_push_o          = 1'b1;
        out_data_o.is_total = 1'b0;
        out_data_o.value    = VALUE_W'(best_prof_q);
        out_data_o.slot     = DL_W'(s_q);
        out_data_o.last     = 1'b0;
        if (!out_full_i) begin
          k_d     = k_q + CW'(1);
          i_d     = '0;
          found_d = 1'b0;
        end
      end
      ST_TOTAL: begin
        out_push_o          = 1'b1;
        out_data_o.is_total = 1'b1;
        // The total saturates at the largest value the result field holds.
        out_data_o.value    = total_q[TOTAL_W-1] ? '1 : total_q[VALUE_W-1:0];
        out_data_o.slot     = '0;
        out_data_o.last     = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      wcnt_q    <= '0;
      n_q       <= '0;
      k_q       <= '0;
      i_q       <= '0;
      visited_q <= '0;
      found_q   <= 1'b0;
      busy_q    <= '0;
      s_q       <= '0;
      total_q   <= '0;
    end else begin
      state_q   <= state_d;
      wcnt_q    <= wcnt_d;
      n_q       <= n_d;
      k_q       <= k_d;
      i_q       <= i_d;
      visited_q <= visited_d;
      found_q   <= found_d;
      busy_q    <= busy_d;
      s_q       <= s_d;
      total_q   <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_idx_q  <= best_idx_d;
    best_prof_q <= best_prof_d;
    best_dl_q   <= best_dl_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wcnt_q[IW-1:0]] <= mem_wd;
    end
    rd_q <= mem[i_q];
  end

endmodule

/* rtl/djs_checker.sv */
// Port-level checker for the job sequencer, bound to the top level.
`include "deadline_job_sequencer_macros.svh"

module djs_checker
  import djs_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = DEF_SLOT_COUNT
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input logic               is_total_o,
  input logic [VALUE_W-1:0] result_value_o,
  input logic [DL_W-1:0]    slot_taken_o,
  input logic               last_result_o
);

  // Only the total record closes a run, and it never names a slot.
  `DJS_ASSERT_IMP(a_last_is_total, !empty && last_result_o, is_total_o, "last record is not a total")
  `DJS_ASSERT_IMP(a_total_fields, !empty && is_total_o, (slot_taken_o == '0) && last_result_o, "total record fields wrong")

  // A scheduled task holds a real slot and a single task's profit.
  `DJS_ASSERT_IMP(a_task_slot, !empty && !is_total_o, (slot_taken_o != '0) && (slot_taken_o <= DL_W'(SLOT_COUNT)), "task slot out of range")
  `DJS_ASSERT_IMP(a_task_value, !empty && !is_total_o, result_value_o[VALUE_W-1:PROFIT_W] == '0, "task value exceeds profit width")

  `DJS_ASSERT_NXT(a_stall_hold, !empty && !pop, !empty && $stable(result_value_o) && $stable(slot_taken_o), "stalled result changed")

endmodule

bind deadline_job_sequencer djs_checker #(
  .SLOT_COUNT (SLOT_COUNT)
) u_djs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .empty          (empty),
  .pop            (pop),
  .is_total_o     (is_total_o),
  .result_value_o (result_value_o),
  .slot_taken_o   (slot_taken_o),
  .last_result_o  (last_result_o)
);
